### sv/sha256_stream_hash_unit_macros.svh
// Assertion macros used by the checker file of the hash unit.
`ifndef SHA256_STREAM_HASH_UNIT_MACROS_SVH
`define SHA256_STREAM_HASH_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hash unit check failed");
// Next-cycle implication checked outside reset.
`define SHU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hash unit check failed");
`endif

### sv/shs_pkg.sv
// Package with the types, constants and rotate helper of the hash unit.
`timescale 1ns / 1ps
package shs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Working variables a..h passed between the round unit and the sequencer.
    typedef struct packed {
        logic [31:0] a, b, c, d, e, f, g, h;
    } work_t;

endpackage

### sv/shs_round.sv
// One SHA-256 round with the message schedule step, reused for all 64 rounds.
`timescale 1ns / 1ps
module shs_round (
    input  shs_pkg::work_t  work_in,
    input  logic [31:0]     w_cur,
    input  logic [31:0]     k_cur,
    input  logic [31:0]     w_m2,
    input  logic [31:0]     w_m7,
    input  logic [31:0]     w_m15,
    input  logic [31:0]     w_m16,
    output shs_pkg::work_t  work_out,
    output logic [31:0]     w_new
);
    logic [31:0] big1, ch, t1, big0, maj, t2, s0, s1;

    always_comb begin
        big1 = shs_pkg::rotr(work_in.e, 6) ^ shs_pkg::rotr(work_in.e, 11)
             ^ shs_pkg::rotr(work_in.e, 25);
        ch   = (work_in.e & work_in.f) ^ (~work_in.e & work_in.g);
        t1   = work_in.h + big1 + ch + k_cur + w_cur;
        big0 = shs_pkg::rotr(work_in.a, 2) ^ shs_pkg::rotr(work_in.a, 13)
             ^ shs_pkg::rotr(work_in.a, 22);
        maj  = (work_in.a & work_in.b) ^ (work_in.a & work_in.c) ^ (work_in.b & work_in.c);
        t2   = big0 + maj;
        work_out.h = work_in.g;
        work_out.g = work_in.f;
        work_out.f = work_in.e;
        work_out.e = work_in.d + t1;
        work_out.d = work_in.c;
        work_out.c = work_in.b;
        work_out.b = work_in.a;
        work_out.a = t1 + t2;
        s0 = shs_pkg::rotr(w_m15, 7) ^ shs_pkg::rotr(w_m15, 18) ^ (w_m15 >> 3);
        s1 = shs_pkg::rotr(w_m2, 17) ^ shs_pkg::rotr(w_m2, 19) ^ (w_m2 >> 10);
        w_new = s1 + w_m7 + s0 + w_m16;
    end
endmodule

### sv/sha256_stream_hash_unit.sv
// Streaming SHA-256 hash unit: byte input, eight digest words out per message.
// A byte that does not fill the block is simply stored; a full block then runs its rounds
// and one fold in the shared round unit, and no request is taken while they run.
// An end request adds padding (one or two padded blocks) plus the rounds,
// and then eight digest requests, one per cycle as the sink accepts them.
// Synchronous active-low reset restores the initial hash, clears the fill and count.
`timescale 1ns / 1ps
module sha256_stream_hash_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);
    // The 16-word schedule window is a shift line; incoming bytes fill it byte by byte.
    // Bytes are collected into the window directly: byte n lands in word n/4.
    shs_pkg::state_t state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] win_reg  [16];
    logic [6:0]  fill_reg;       // bytes in the current block
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;        // round counter or pad position
    logic        final_reg;      // the block in flight is the last of the message
    logic        pend_end_reg, pend_end_next;
    logic [2:0]  oidx_reg;
    shs_pkg::work_t work_reg, work_rnd;
    logic [31:0] w_new;

    shs_round u_round (
        .work_in (work_reg),
        .w_cur   (win_reg[0]),
        .k_cur   (shs_pkg::ROUND_K[rnd_reg]),
        .w_m2    (win_reg[14]),
        .w_m7    (win_reg[9]),
        .w_m15   (win_reg[1]),
        .w_m16   (win_reg[0]),
        .work_out(work_rnd),
        .w_new   (w_new)
    );

    // Returns the window word with one byte replaced; byte 0 is the most significant.
    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] bi,
                                             input logic [7:0] b);
        logic [31:0] res;
        res = word;
        res[8*(3-bi) +: 8] = b;
        return res;
    endfunction

    logic [31:0] win_next [16];
    logic [6:0]  fill_next;
    logic [63:0] bits_next;
    logic [5:0]  rnd_next;
    logic        final_next;

    always_comb begin
        state_next = state_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        final_next = final_reg;
        unique case (state_reg)
            shs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        win_next[fill_reg[5:2]] = put_byte(win_next[fill_reg[5:2]],
                                                           fill_reg[1:0], s_tdata);
                        bits_next = bits_reg + 64'd8;
                    end
                    if (s_tuser && fill_reg == 7'd63) begin
                        fill_next  = 7'd0;
                        rnd_next   = 6'd0;
                        final_next = 1'b0;
                        // the end flag is replayed after this block: remember it
                        state_next = shs_pkg::ST_ROUND;
                    end else if (s_tuser) begin
                        fill_next = fill_reg + 7'd1;
                    end
                    if (s_tlast) begin
                        // Pad marker goes at the fill after the byte, if any.
                        if (!(s_tuser && fill_reg == 7'd63)) begin
                            win_next[fill_next[5:2]] = put_byte(win_next[fill_next[5:2]],
                                                                fill_next[1:0],
                                                                shs_pkg::PAD_MARK);
                            rnd_next   = fill_next[5:0] + 6'd1;
                            fill_next  = fill_next + 7'd1;
                            state_next = (fill_next == 7'd64) ? shs_pkg::ST_ROUND
                                                               : shs_pkg::ST_PAD;
                            if (fill_next == 7'd64) rnd_next = 6'd0;
                        end
                    end
                end
            end
            shs_pkg::ST_PAD: begin
                // one zero or length byte per cycle, at position rnd_reg
                if (fill_reg > 7'd56) begin
                    win_next[rnd_reg[5:2]] = put_byte(win_next[rnd_reg[5:2]],
                                                      rnd_reg[1:0], 8'h00);
                    if (rnd_reg == 6'd63) begin
                        rnd_next   = 6'd0;
                        final_next = 1'b0;
                        state_next = shs_pkg::ST_ROUND;
                    end else begin
                        rnd_next = rnd_reg + 6'd1;
                    end
                end else begin
                    if (rnd_reg >= shs_pkg::LEN_POS)
                        win_next[rnd_reg[5:2]] = put_byte(win_next[rnd_reg[5:2]],
                                                          rnd_reg[1:0],
                                                          bits_reg[8*(7-(rnd_reg[2:0])) +: 8]);
                    else
                        win_next[rnd_reg[5:2]] = put_byte(win_next[rnd_reg[5:2]],
                                                          rnd_reg[1:0], 8'h00);
                    if (rnd_reg == 6'd63) begin
                        rnd_next   = 6'd0;
                        final_next = 1'b1;
                        state_next = shs_pkg::ST_ROUND;
                    end else begin
                        rnd_next = rnd_reg + 6'd1;
                    end
                end
            end
            shs_pkg::ST_ROUND: begin
                for (int i = 0; i < 15; i++) win_next[i] = win_reg[i+1];
                win_next[15] = w_new;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) state_next = shs_pkg::ST_FOLD;
            end
            shs_pkg::ST_FOLD: begin
                if (final_reg) begin
                    state_next = shs_pkg::ST_OUT;
                end else if (pend_end_reg) begin
                    // Second padding block: zeros up to the length field. When the
                    // ending byte filled the previous block, the marker opens this one.
                    if (fill_reg == 7'd0) begin
                        win_next[0] = put_byte(win_next[0], 2'd0, shs_pkg::PAD_MARK);
                        rnd_next    = 6'd1;
                    end else begin
                        rnd_next = 6'd0;
                    end
                    fill_next  = 7'd0;
                    state_next = shs_pkg::ST_PAD;
                end else begin
                    state_next = shs_pkg::ST_IDLE;
                end
            end
            shs_pkg::ST_OUT: begin
                if (m_tready && oidx_reg == 3'd7) begin
                    fill_next  = 7'd0;
                    bits_next  = 64'd0;
                    final_next = 1'b0;
                    state_next = shs_pkg::ST_IDLE;
                end
            end
            default: state_next = shs_pkg::ST_IDLE;
        endcase
    end

    // An end request that arrives with the byte that fills a block, or whose marker
    // leaves no room for the length, needs a second block; this flag carries it.
    always_comb begin
        pend_end_next = pend_end_reg;
        if (state_reg == shs_pkg::ST_IDLE && s_tvalid && s_tlast) begin
            pend_end_next = (s_tuser && fill_reg == 7'd63) || (fill_next == 7'd64);
        end else if (state_reg == shs_pkg::ST_PAD && fill_reg > 7'd56 && rnd_reg == 6'd63) begin
            pend_end_next = 1'b1;
        end else if (state_reg == shs_pkg::ST_FOLD) begin
            if (final_reg) pend_end_next = 1'b0;
            else if (pend_end_reg) pend_end_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        if (!aresetn) begin
            state_reg    <= shs_pkg::ST_IDLE;
            fill_reg     <= 7'd0;
            bits_reg     <= 64'd0;
            rnd_reg      <= 6'd0;
            final_reg    <= 1'b0;
            pend_end_reg <= 1'b0;
            oidx_reg     <= 3'd0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= shs_pkg::INIT_HASH[i];
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            rnd_reg      <= rnd_next;
            final_reg    <= final_next;
            pend_end_reg <= pend_end_next;
            if (state_reg == shs_pkg::ST_FOLD) begin
                hash_reg[0] <= hash_reg[0] + work_reg.a;
                hash_reg[1] <= hash_reg[1] + work_reg.b;
                hash_reg[2] <= hash_reg[2] + work_reg.c;
                hash_reg[3] <= hash_reg[3] + work_reg.d;
                hash_reg[4] <= hash_reg[4] + work_reg.e;
                hash_reg[5] <= hash_reg[5] + work_reg.f;
                hash_reg[6] <= hash_reg[6] + work_reg.g;
                hash_reg[7] <= hash_reg[7] + work_reg.h;
            end
            if (state_reg == shs_pkg::ST_OUT && m_tready) begin
                oidx_reg <= oidx_reg + 3'd1;
                if (oidx_reg == 3'd7)
                    for (int i = 0; i < 8; i++) hash_reg[i] <= shs_pkg::INIT_HASH[i];
            end
        end
    end

    // Working variables load from the chain at round 0 and advance once per round.
    always_ff @(posedge aclk) begin
        if (state_reg != shs_pkg::ST_ROUND && state_next == shs_pkg::ST_ROUND)
            work_reg <= '{hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                          hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};
        else if (state_reg == shs_pkg::ST_ROUND)
            work_reg <= work_rnd;
    end

    assign s_tready = (state_reg == shs_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == shs_pkg::ST_OUT);
    assign m_tdata  = {5'd0, oidx_reg, hash_reg[oidx_reg]};
    assign m_tlast  = (oidx_reg == 3'd7);
endmodule

### sv/shs_checker.sv
// Port-level checker for the hash unit, bound to the top level.
`timescale 1ns / 1ps
`include "sha256_stream_hash_unit_macros.svh"
module shs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    // No request is taken while digest words are being offered.
    `SHU_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    // The last word carries index seven.
    `SHU_ASSERT_IMP(a_last_idx, aclk, aresetn, m_tvalid && m_tlast, m_tdata[34:32] == 3'd7)
    // After the last word is taken, the unit is ready for a new message.
    `SHU_ASSERT_NEXT(a_ready_after, aclk, aresetn, m_tvalid && m_tready && m_tlast,
        s_tready && !m_tvalid)
    // Word index advances by one after each accepted non-final word.
    `SHU_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
endmodule

bind sha256_stream_hash_unit shs_checker u_shs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

### bench/tb_top.sv
// Self-checking bench for the streaming SHA-256 hash unit.
`timescale 1ns / 1ps
module tb_top;

    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // has_byte
    logic        s_tlast;   // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
    logic        m_tlast;   // last_word

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_req_t;

    // Predictor state, mirroring the block's message state.
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int unsigned fill_count;
    logic [63:0] bit_count;

    digest_req_t pending_words[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned sink_wait;
    bit          sink_busy_ok;
    bit          timed_out;

    sha256_stream_hash_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression of the current block into the chaining hash.
    task automatic fold_block();
        logic [31:0] sched [64];
        logic [31:0] wv [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            sched[t] = {block_bytes[4*t], block_bytes[4*t+1],
                        block_bytes[4*t+2], block_bytes[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
        end
        for (int i = 0; i < 8; i++) wv[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = wv[7] + (ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + shs_pkg::ROUND_K[t] + sched[t];
            t2 = (ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6]; wv[6] = wv[5]; wv[5] = wv[4]; wv[4] = wv[3] + t1;
            wv[3] = wv[2]; wv[2] = wv[1]; wv[1] = wv[0]; wv[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += wv[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) hash_state[i] = shs_pkg::INIT_HASH[i];
        fill_count = 0;
        bit_count  = '0;
    endtask

    // Applies one accepted request to the predictor and queues any digest words.
    task automatic predict_request(logic [7:0] data, logic has_byte, logic closes);
        int unsigned pos;
        digest_req_t req;
        if (has_byte) begin
            block_bytes[fill_count] = data;
            fill_count++;
            bit_count += 64'd8;
            if (fill_count == 64) begin
                fold_block();
                fill_count = 0;
            end
        end
        if (closes) begin
            pos = fill_count;
            block_bytes[pos] = shs_pkg::PAD_MARK;
            pos++;
            // Too little room for the length: pad out and fold an extra block.
            if (pos > shs_pkg::LEN_POS) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                fold_block();
                pos = 0;
            end
            while (pos < shs_pkg::LEN_POS) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[shs_pkg::LEN_POS + i] = bit_count[63 - 8*i -: 8];
            fold_block();
            for (int i = 0; i < 8; i++) begin
                req.word  = hash_state[i];
                req.index = i[2:0];
                req.last  = (i == 7);
                pending_words.push_back(req);
            end
            restart_message();
        end
    endtask

    // Drives one request and waits for it to be taken; valid stays up until the
    // next request draws a gap or the sender goes quiet.
    task automatic send_request(logic [7:0] data, logic has_byte, logic closes,
                                bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= closes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(data, has_byte, closes);
        @(negedge aclk);
    endtask

    task automatic send_message(int unsigned len, bit full_rate = 0);
        for (int unsigned i = 0; i < len; i++)
            send_request(8'($urandom_range(0, 255)), 1'b1, (i == len - 1), full_rate);
        if (len == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, full_rate);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_words.size() != 0 && !timed_out) @(negedge aclk);
    endtask

    // Field extremes, empty message and a request that carries nothing.
    task automatic test_directed();
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'ha5, 1'b1, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b0, 1'b1);
    endtask

    // Lengths around the padding boundary, on both sides of where an extra block is needed.
    task automatic test_padding_edges();
        int unsigned lens [4] = '{55, 56, 63, 64};
        foreach (lens[i]) send_message(lens[i], 1);
    endtask

    // Random messages mixed with requests that carry no byte.
    task automatic test_random_messages();
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < 200) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(0, 12);
            for (int unsigned i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    sent++;
                end
                send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            sent += len + 1;
        end
    endtask

    // The sender holds off until every digest word of the last message is out.
    task automatic test_drain_pause();
        send_message(5);
        wait_drained();
        send_message(3, 1);
    endtask

    // Output side: each result waits a drawn number of offered cycles before ready.
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= (sink_wait == 0);
    end

    // Comparison against the oldest expectation and the sink wait countdown.
    always @(posedge aclk) begin
        digest_req_t want;
        if (!aresetn) begin
            sink_wait = 0;
        end else if (m_tvalid && m_tready) begin
            sink_wait = sink_busy_ok ? $urandom_range(0, 17) : 0;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected digest word %h", m_tdata);
            end else begin
                want = pending_words.pop_front();
                if (m_tdata[31:0] !== want.word || m_tdata[34:32] !== want.index
                    || m_tdata[39:35] !== 5'd0 || m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 want.word, want.index, want.last,
                                 m_tdata[31:0], m_tdata[34:32], m_tlast);
                end
            end
        end else if (m_tvalid && sink_wait > 0) begin
            sink_wait = sink_wait - 1;
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("sha256_stream_hash_unit verification failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        sink_busy_ok = 1'b0;
        restart_message();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_padding_edges();
        sink_busy_ok = 1'b1;
        test_drain_pause();
        test_random_messages();
        wait_drained();
        repeat (200) @(negedge aclk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("sha256_stream_hash_unit verification clean");
        else
            $display("sha256_stream_hash_unit verification failed");
        $finish;
    end
endmodule
